/* src/sms_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the stable merge sorter.
package sms_pkg;

	localparam int MaxItems  = 64;
	localparam int KeyBits   = 32;
	localparam int AddrBits  = $clog2(MaxItems);
	localparam int CountBits = AddrBits + 1;
	localparam int EntryBits = 64;

	// Configuration register indexes.
	localparam logic CfgDescending = 1'b0;
	localparam logic CfgSignedKeys = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_LATCH,
		ST_SWEEP,
		ST_PLACE,
		ST_EMIT_RD,
		ST_EMIT_LOAD,
		ST_EMIT_HOLD
	} state_t;

	typedef struct packed {
		logic load_en;
		logic fetch;
		logic latch;
		logic sweep;
		logic place;
		logic emit_load;
		logic emit_hold;
	} cmd_t;

	typedef struct packed {
		logic final_acc;
		logic sweep_done;
		logic last_place;
		logic out_acc;
		logic out_last;
	} status_t;

endpackage

/* src/sms_if.sv */
`timescale 1ns / 1ps
// Stream interfaces for input items and sorted results.
interface sms_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] key;
	logic [31:0] payload;
	logic        final_item;
	modport source (output valid, key, payload, final_item, input ready);
	modport sink (input valid, key, payload, final_item, output ready);
endinterface

interface sms_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] sorted_key;
	logic [31:0] sorted_payload;
	logic        end_of_run;
	logic        items_dropped;
	modport source (output valid, sorted_key, sorted_payload, end_of_run, items_dropped,
		input ready);
	modport sink (input valid, sorted_key, sorted_payload, end_of_run, items_dropped,
		output ready);
endinterface

/* src/sms_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sms_ram #(
	parameter int Width = 64,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/sms_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: load, rank each item, place it, then emit.
module sms_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  sms_pkg::status_t status,
	output sms_pkg::cmd_t    cmd
);
	sms_pkg::state_t state_q, state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sms_pkg::ST_LOAD: begin
				if (status.final_acc) state_d = sms_pkg::ST_FETCH;
			end
			sms_pkg::ST_FETCH: state_d = sms_pkg::ST_LATCH;
			sms_pkg::ST_LATCH: state_d = sms_pkg::ST_SWEEP;
			sms_pkg::ST_SWEEP: begin
				if (status.sweep_done) state_d = sms_pkg::ST_PLACE;
			end
			sms_pkg::ST_PLACE: begin
				state_d = status.last_place ? sms_pkg::ST_EMIT_RD : sms_pkg::ST_FETCH;
			end
			sms_pkg::ST_EMIT_RD: state_d = sms_pkg::ST_EMIT_LOAD;
			sms_pkg::ST_EMIT_LOAD: state_d = sms_pkg::ST_EMIT_HOLD;
			sms_pkg::ST_EMIT_HOLD: begin
				if (status.out_acc) begin
					state_d = status.out_last ? sms_pkg::ST_LOAD : sms_pkg::ST_EMIT_RD;
				end
			end
			default: state_d = sms_pkg::ST_LOAD;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		case (state_q)
			sms_pkg::ST_LOAD:      cmd.load_en = 1'b1;
			sms_pkg::ST_FETCH:     cmd.fetch = 1'b1;
			sms_pkg::ST_LATCH:     cmd.latch = 1'b1;
			sms_pkg::ST_SWEEP:     cmd.sweep = 1'b1;
			sms_pkg::ST_PLACE:     cmd.place = 1'b1;
			sms_pkg::ST_EMIT_LOAD: cmd.emit_load = 1'b1;
			sms_pkg::ST_EMIT_HOLD: cmd.emit_hold = 1'b1;
			default:               cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sms_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

/* src/sms_datapath.sv */
`timescale 1ns / 1ps
// Datapath: item store, rank counting sweep, sorted store and output register.
module sms_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic                        cfg_data,
	input  sms_pkg::cmd_t               cmd,
	output sms_pkg::status_t            status,
	sms_in_if.sink                      in_ch,
	sms_out_if.source                   out_ch
);
	logic                             desc_cfg_q, sgn_cfg_q, desc_q, sgn_q;
	logic [sms_pkg::CountBits-1:0]    cnt_q, j_q;
	logic                             ovf_q;
	logic [sms_pkg::AddrBits-1:0]     i_q, k_q, rank_q;
	logic [sms_pkg::EntryBits-1:0]    cur_q, store_rdata, sorted_rdata;
	logic                             in_fire, store_we, room, precedes;
	logic [sms_pkg::AddrBits-1:0]     store_raddr;
	logic [sms_pkg::KeyBits-1:0]      rank_cur, rank_other;
	logic                             out_valid_q, out_last_q;
	logic [31:0]                      out_key_q, out_payload_q;

	assign in_ch.ready = cmd.load_en;
	assign in_fire     = in_ch.valid & cmd.load_en;
	assign room        = cnt_q < sms_pkg::CountBits'(sms_pkg::MaxItems);
	assign store_we    = in_fire & room;
	assign store_raddr = cmd.fetch ? i_q : j_q[sms_pkg::AddrBits-1:0];

	sms_ram #(.Width(sms_pkg::EntryBits), .Depth(sms_pkg::MaxItems)) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (cnt_q[sms_pkg::AddrBits-1:0]),
		.wdata ({in_ch.key, in_ch.payload}),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	sms_ram #(.Width(sms_pkg::EntryBits), .Depth(sms_pkg::MaxItems)) u_sorted (
		.clk   (clk),
		.we    (cmd.place),
		.waddr (rank_q),
		.wdata (cur_q),
		.raddr (k_q),
		.rdata (sorted_rdata)
	);

	// Keys mapped to unsigned ranks; the other item goes first if it ranks
	// strictly ahead, or ties and arrived earlier.
	assign rank_cur   = cur_q[63:32] ^ {sgn_q, {(sms_pkg::KeyBits-1){1'b0}}};
	assign rank_other = store_rdata[63:32] ^ {sgn_q, {(sms_pkg::KeyBits-1){1'b0}}};
	always_comb begin
		if (rank_cur == rank_other) begin
			precedes = j_q <= {1'b0, i_q};
		end else if (desc_q) begin
			precedes = rank_cur < rank_other;
		end else begin
			precedes = rank_cur > rank_other;
		end
	end

	assign status.final_acc  = in_fire & in_ch.final_item;
	assign status.sweep_done = j_q == cnt_q;
	assign status.last_place = ({1'b0, i_q} + 1'b1) == cnt_q;
	assign status.out_acc    = out_valid_q & out_ch.ready;
	assign status.out_last   = out_last_q;

	assign out_ch.valid          = out_valid_q;
	assign out_ch.sorted_key     = out_key_q;
	assign out_ch.sorted_payload = out_payload_q;
	assign out_ch.end_of_run     = out_last_q;
	assign out_ch.items_dropped  = ovf_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_cfg_q  <= 1'b0;
			sgn_cfg_q   <= 1'b0;
			desc_q      <= 1'b0;
			sgn_q       <= 1'b0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == sms_pkg::CfgDescending) desc_cfg_q <= cfg_data;
			if (cfg_we && cfg_index == sms_pkg::CfgSignedKeys) sgn_cfg_q <= cfg_data;
			if (in_fire) begin
				if (room) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
				if (in_ch.final_item) begin
					desc_q <= desc_cfg_q;
					sgn_q  <= sgn_cfg_q;
					i_q    <= '0;
					k_q    <= '0;
				end
			end
			// The sweep of each item starts reading at entry zero.
			if (cmd.fetch) begin
				rank_q <= '0;
				j_q    <= '0;
			end
			if (cmd.latch) j_q <= sms_pkg::CountBits'(1);
			if (cmd.sweep) begin
				rank_q <= rank_q + sms_pkg::AddrBits'(precedes);
				if (j_q != cnt_q) j_q <= j_q + 1'b1;
			end
			if (cmd.place) i_q <= i_q + 1'b1;
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
				out_last_q  <= ({1'b0, k_q} + 1'b1) == cnt_q;
			end
			if (cmd.emit_hold && status.out_acc) begin
				out_valid_q <= 1'b0;
				k_q         <= k_q + 1'b1;
				if (out_last_q) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) cur_q <= store_rdata;
		if (cmd.emit_load) begin
			out_key_q     <= sorted_rdata[63:32];
			out_payload_q <= sorted_rdata[31:0];
		end
	end
endmodule

/* src/stable_merge_sorter_top.sv */
`timescale 1ns / 1ps
// Stable key sorter: takes a set of key/payload requests and returns them sorted.
// Usage:
// Requests arrive on sort_in (key, payload, final_item); one is taken per cycle
// while the block is loading. The request flagged final_item closes the set.
// Up to 64 items are kept; later ones are discarded and every result of that set
// carries items_dropped. Keys sort ascending or descending (register 0) and as
// unsigned or two's complement (register 1); the values at the final request apply.
// Equal keys leave in arrival order.
// After the final request each stored item is ranked by a sweep over the item RAM,
// one comparison per cycle. Results then leave on sort_out one at a time, each
// read from the sorted RAM and registered, the last one flagged end_of_run.
// A stalled receiver holds the result register; nothing is lost.
// No new request is taken until the last result of the set is accepted.
// Reset clears the configuration, the item count and the drop flag.
module stable_merge_sorter_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic cfg_data,
	sms_in_if.sink    sort_in,
	sms_out_if.source sort_out
);
	sms_pkg::cmd_t    cmd;
	sms_pkg::status_t status;

	sms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	sms_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.in_ch     (sort_in),
		.out_ch    (sort_out)
	);
endmodule

/* src/sms_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the sorter, bound to the top level.
module sms_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);
	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// Loading and emitting never overlap.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is offered");

	// The end of a set frees the result register and returns the block to loading.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid && in_ready)
		else $error("block not back to loading after end of set");

	// Within a set no request is taken between results.
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> !in_ready)
		else $error("request taken in the middle of a set");
endmodule

bind stable_merge_sorter_top sms_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sort_in.ready),
	.out_valid (sort_out.valid),
	.out_ready (sort_out.ready),
	.out_last  (sort_out.end_of_run)
);
